// ===== hdl/lmsw_pkg.sv =====
// ----------------------------------------------------------------------------
// lmsw_pkg
// Shared sizes, codes and types for the local mean / std window filter.
// ----------------------------------------------------------------------------
package lmsw_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 7;
    localparam int PIXEL_BITS = 16;
    localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int SROW_BITS  = $clog2(STORE_ROWS);
    localparam int ADDR_BITS  = SROW_BITS + COL_BITS;
    localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;

    // sums: 225 pixels max
    localparam int S_BITS  = 24;
    localparam int S2_BITS = 40;
    localparam int N_BITS  = 8;
    localparam int VAR_BITS = 64;
    localparam int ROOT_BITS = 40;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    typedef struct packed {
        logic [S_BITS-1:0]   s;
        logic [S2_BITS-1:0]  s2;
        logic [N_BITS-1:0]   n;
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        logic                last;
    } sums_t;

    typedef struct packed {
        logic [23:0]         mean;
        logic [23:0]         sd;
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        logic                last;
    } result_t;

endpackage

// ===== hdl/lmsw_store.sv =====
// ----------------------------------------------------------------------------
// lmsw_store
// Row pixel store: single write port, single registered read port.
// ----------------------------------------------------------------------------
module lmsw_store (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [lmsw_pkg::ADDR_BITS-1:0] wr_addr,
    input  logic [lmsw_pkg::PIXEL_BITS-1:0] wr_data,
    input  logic                           rd_en,
    input  logic [lmsw_pkg::ADDR_BITS-1:0] rd_addr,
    output logic [lmsw_pkg::PIXEL_BITS-1:0] rd_data
);
    logic [lmsw_pkg::PIXEL_BITS-1:0] mem [lmsw_pkg::DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== hdl/lmsw_math.sv =====
// ----------------------------------------------------------------------------
// lmsw_math
// Mean and std from window sums: registered variance product,
// bit-serial square root, restoring dividers.
// ----------------------------------------------------------------------------
module lmsw_math (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  lmsw_pkg::sums_t   sums,
    output logic              busy,
    output logic              done,
    output lmsw_pkg::result_t res
);
    typedef enum logic [5:0] {
        M_IDLE = 6'b000001,
        M_MUL1 = 6'b000010,
        M_MUL2 = 6'b000100,
        M_SQRT = 6'b001000,
        M_DIV  = 6'b010000,
        M_DONE = 6'b100000
    } mstate_t;

    mstate_t state_reg, state_next;
    lmsw_pkg::sums_t in_reg;
    logic [63:0] a_reg, b_reg;
    logic [63:0] rem_reg, root_reg, bit_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] mq_reg;   // mean quotient
    logic [8:0]  mr_reg;
    logic [39:0] sq_reg;   // std quotient (root dividend shifts out)
    logic [8:0]  sr_reg;
    logic [63:0] var_w;
    logic [63:0] t_w;
    logic [9:0]  mtry, stry;

    assign busy = (state_reg != M_IDLE);
    assign done = (state_reg == M_DONE);
    assign var_w = a_reg - b_reg;
    assign t_w = root_reg + bit_reg;
    assign mtry = {mr_reg, mq_reg[31]};
    assign stry = {sr_reg, sq_reg[39]};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE: if (start) state_next = M_MUL1;
            M_MUL1: state_next = M_MUL2;
            M_MUL2: state_next = M_SQRT;
            M_SQRT: if (cnt_reg == 6'd31) state_next = M_DIV;
            M_DIV:  if (cnt_reg == 6'd39) state_next = M_DONE;
            M_DONE: state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
        end else begin
            state_reg <= state_next;
        end
        case (state_reg)
            M_IDLE: begin
                in_reg  <= sums;
                cnt_reg <= '0;
            end
            M_MUL1: begin
                a_reg <= 64'(in_reg.s2) * 64'(in_reg.n);
                b_reg <= 64'(in_reg.s) * 64'(in_reg.s);
            end
            M_MUL2: begin
                rem_reg  <= {var_w[47:0], 16'd0};
                root_reg <= '0;
                bit_reg  <= 64'd1 << 62;
                mq_reg   <= {in_reg.s, 8'd0};
                mr_reg   <= '0;
                cnt_reg  <= '0;
            end
            M_SQRT: begin
                if (rem_reg >= t_w) begin
                    rem_reg  <= rem_reg - t_w;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= (cnt_reg == 6'd31) ? 6'd0 : cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    sq_reg <= '0;
                    sr_reg <= '0;
                end
            end
            M_DIV: begin
                if (cnt_reg == 6'd0) begin
                    sq_reg <= root_reg[39:0];
                end else begin
                    sq_reg <= {sq_reg[38:0], stry >= 10'(in_reg.n)};
                    sr_reg <= (stry >= 10'(in_reg.n)) ? 9'(stry - 10'(in_reg.n)) : 9'(stry);
                end
                if (cnt_reg < 6'd32) begin
                    mq_reg <= {mq_reg[30:0], mtry >= 10'(in_reg.n)};
                    mr_reg <= (mtry >= 10'(in_reg.n)) ? 9'(mtry - 10'(in_reg.n)) : 9'(mtry);
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            default: ;
        endcase
    end

    // sq_reg took 39 shift steps after load; one more step happens at done
    logic [39:0] sq_fin;
    assign sq_fin = {sq_reg[38:0], stry >= 10'(in_reg.n)};

    always_comb begin
        res.mean = mq_reg[23:0];
        res.sd   = sq_fin[23:0];
        res.col  = in_reg.col;
        res.row  = in_reg.row;
        res.last = in_reg.last;
    end
endmodule

// ===== hdl/local_mean_std_window_filter.sv =====
// ----------------------------------------------------------------------------
// local_mean_std_window_filter
// Box filter mean / population std with clipped borders, 8 fraction bits.
// ----------------------------------------------------------------------------
// Sequence: m_tvalid rises after the transaction that triggers a result, once
//   the scan has read the N pixels of the clipped window (at most (2r+1)^2),
//   the start state has passed and the math has run (mul, sqrt, divide, done).
// Flow: sequential; an item that yields a result holds the input until
//   the result is taken; other items are taken back to back while cfg_valid is low.
// Reset: synchronous, active low; width 1024, height 1024, radius 1,
//   counters zero. The pixel store needs no clearing.
module local_mean_std_window_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] pixel_value
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [23:0] mean_value, [47:24] std_value,
                                   // [57:48] out_column, [69:58] out_row, pad
    output logic        m_tlast,   // frame_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    localparam int CB = lmsw_pkg::COL_BITS;
    localparam int RB = lmsw_pkg::ROW_BITS;
    localparam int AB = lmsw_pkg::ADDR_BITS;
    localparam int SB = lmsw_pkg::SROW_BITS;
    localparam int NB = lmsw_pkg::COL_BITS + lmsw_pkg::ROW_BITS + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_MATH  = 5'b00100,
        S_WAIT  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg;
    logic [10:0] w_cfg_reg;
    logic [12:0] h_cfg_reg;
    logic [2:0]  r_cfg_reg;
    logic [CB-1:0] in_col_reg, out_col_reg;
    logic [RB-1:0] in_row_reg, out_row_reg;
    logic [SB-1:0] in_srow_reg;
    logic [NB-1:0] in_cnt_reg, out_cnt_reg;   // raster indices of in / out
    logic received_reg;

    // effective configuration (clamped)
    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic [2:0]  r_eff;
    assign w_eff = (w_cfg_reg == 11'd0) ? 11'd1 : (w_cfg_reg > 11'd1024 ? 11'd1024 : w_cfg_reg);
    assign h_eff = (h_cfg_reg == 13'd0) ? 13'd1 : (h_cfg_reg > 13'd4096 ? 13'd4096 : h_cfg_reg);
    assign r_eff = r_cfg_reg;

    // store
    logic wr_en, rd_en;
    logic [AB-1:0] wr_addr, rd_addr;
    logic [15:0] rd_data;
    lmsw_store u_store (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(s_tdata),
        .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // window scan
    logic [RB:0] y1_reg, y_reg;
    logic [CB:0] x0_reg, x1_reg, x_reg;
    logic [SB-1:0] ys_reg;       // y mod STORE_ROWS
    logic rd_vld_reg, scan_end_reg;
    logic [23:0] s_reg;
    logic [39:0] s2_reg;
    logic [7:0]  n_reg;

    lmsw_pkg::sums_t sums;
    logic m_start, m_busy, m_done;
    lmsw_pkg::result_t m_res, res_reg;

    lmsw_math u_math (
        .aclk(aclk), .aresetn(aresetn), .start(m_start), .sums(sums),
        .busy(m_busy), .done(m_done), .res(m_res)
    );

    // config only while nothing is in flight; it wins over an input transaction
    assign cfg_ready = (state_reg == S_IDLE) && !m_busy;
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {2'd0, res_reg.row, res_reg.col, res_reg.sd, res_reg.mean};
    assign m_tlast   = res_reg.last;

    logic acc, is_pix, pix_ok;
    assign acc    = s_tvalid && s_tready;
    assign is_pix = (s_tuser == lmsw_pkg::OP_PIXEL);
    assign pix_ok = acc && is_pix && !received_reg;
    assign wr_en  = pix_ok;
    assign wr_addr = {in_srow_reg, in_col_reg};

    // input counters after this transaction
    logic [CB:0] nin_col;
    logic [RB:0] nin_row;
    logic        n_recv;
    logic wrap_c, wrap_r;
    always_comb begin
        nin_col = {1'b0, in_col_reg};
        nin_row = {1'b0, in_row_reg};
        n_recv  = received_reg;
        wrap_c = 1'b0;
        wrap_r = 1'b0;
        if (pix_ok) begin
            nin_col = nin_col + 1'b1;
            if (nin_col >= (CB+1)'(w_eff)) begin
                nin_col = '0;
                wrap_c = 1'b1;
                nin_row = nin_row + 1'b1;
                if (nin_row >= (RB+1)'(h_eff)) begin
                    nin_row = '0;
                    wrap_r = 1'b1;
                    n_recv = 1'b1;
                end
            end
        end
    end

    // emission test: whole frame received, or in_count >= out_idx + lag + 1, lag = r*W + r
    logic [NB-1:0] nin_cnt;
    logic [13:0]   lag_w;
    logic emit;
    assign nin_cnt = in_cnt_reg + NB'(pix_ok);
    assign lag_w   = 14'(r_eff) * 14'(w_eff) + 14'(r_eff);
    always_comb begin
        emit = 1'b0;
        if (acc && (pix_ok || (!is_pix && received_reg))) begin
            if (n_recv) emit = 1'b1;
            else emit = (NB+1)'(nin_cnt) > (NB+1)'(out_cnt_reg) + (NB+1)'(lag_w);
        end
    end

    logic out_last;
    assign out_last = ({1'b0, out_col_reg} == (CB+1)'(w_eff - 11'd1)) &&
                      ({1'b0, out_row_reg} == (RB+1)'(h_eff - 13'd1));

    // store row of y
    logic [SB-1:0] ys_init;
    assign ys_init = SB'(({1'b0, out_row_reg} >= (RB+1)'(r_eff) ?
                          {1'b0, out_row_reg} - (RB+1)'(r_eff) : '0)
                         % lmsw_pkg::STORE_ROWS);

    assign rd_en   = (state_reg == S_SCAN) && !scan_end_reg;
    assign rd_addr = {ys_reg, x_reg[CB-1:0]};

    always_comb begin
        sums.s = s_reg;
        sums.s2 = s2_reg;
        sums.n = n_reg;
        sums.col = out_col_reg;
        sums.row = out_row_reg;
        sums.last = out_last;
    end
    assign m_start = (state_reg == S_MATH);

    logic [31:0] sq;
    assign sq = 32'(rd_data) * 32'(rd_data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            w_cfg_reg    <= 11'd1024;
            h_cfg_reg    <= 13'd1024;
            r_cfg_reg    <= 3'd1;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_srow_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            in_cnt_reg   <= '0;
            out_cnt_reg  <= '0;
            received_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
            scan_end_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lmsw_pkg::REG_WIDTH:  w_cfg_reg <= cfg_data[10:0];
                lmsw_pkg::REG_HEIGHT: h_cfg_reg <= cfg_data;
                lmsw_pkg::REG_RADIUS: r_cfg_reg <= cfg_data[2:0];
                default: ;
            endcase
            if (cfg_index inside {lmsw_pkg::REG_WIDTH, lmsw_pkg::REG_HEIGHT,
                                  lmsw_pkg::REG_RADIUS}) begin
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_srow_reg  <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                in_cnt_reg   <= '0;
                out_cnt_reg  <= '0;
                received_reg <= 1'b0;
                state_reg    <= S_IDLE;
            end
        end else begin
            case (state_reg)
                S_IDLE: if (acc) begin
                    in_col_reg   <= nin_col[CB-1:0];
                    in_row_reg   <= nin_row[RB-1:0];
                    in_cnt_reg   <= nin_cnt;
                    received_reg <= n_recv;
                    if (wrap_r) in_srow_reg <= '0;
                    else if (wrap_c) in_srow_reg <= (in_srow_reg == SB'(lmsw_pkg::STORE_ROWS-1))
                                                   ? '0 : in_srow_reg + 1'b1;
                    if (emit) begin
                        y_reg  <= ({1'b0, out_row_reg} >= (RB+1)'(r_eff)) ?
                                  {1'b0, out_row_reg} - (RB+1)'(r_eff) : '0;
                        y1_reg <= ((RB+1)'(out_row_reg) + (RB+1)'(r_eff) < (RB+1)'(h_eff)) ?
                                  (RB+1)'(out_row_reg) + (RB+1)'(r_eff) : (RB+1)'(h_eff - 13'd1);
                        x0_reg <= ({1'b0, out_col_reg} >= (CB+1)'(r_eff)) ?
                                  {1'b0, out_col_reg} - (CB+1)'(r_eff) : '0;
                        x_reg  <= ({1'b0, out_col_reg} >= (CB+1)'(r_eff)) ?
                                  {1'b0, out_col_reg} - (CB+1)'(r_eff) : '0;
                        x1_reg <= ((CB+1)'(out_col_reg) + (CB+1)'(r_eff) < (CB+1)'(w_eff)) ?
                                  (CB+1)'(out_col_reg) + (CB+1)'(r_eff) : (CB+1)'(w_eff - 11'd1);
                        ys_reg <= ys_init;
                        s_reg  <= '0;
                        s2_reg <= '0;
                        n_reg  <= '0;
                        rd_vld_reg   <= 1'b0;
                        scan_end_reg <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // read address walks the window; the store returns registered read data
                    rd_vld_reg <= rd_en;
                    if (rd_vld_reg) begin
                        s_reg  <= s_reg + 24'(rd_data);
                        s2_reg <= s2_reg + 40'(sq);
                        n_reg  <= n_reg + 1'b1;
                    end
                    if (!scan_end_reg) begin
                        if (x_reg == x1_reg) begin
                            x_reg <= x0_reg;
                            ys_reg <= (ys_reg == SB'(lmsw_pkg::STORE_ROWS-1)) ? '0 : ys_reg + 1'b1;
                            y_reg <= y_reg + 1'b1;
                            if (y_reg == y1_reg) scan_end_reg <= 1'b1;
                        end else begin
                            x_reg <= x_reg + 1'b1;
                        end
                    end else if (!rd_vld_reg) begin
                        state_reg <= S_MATH;
                    end
                end
                S_MATH: state_reg <= S_WAIT;
                S_WAIT: if (m_done) begin
                    res_reg   <= m_res;
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_tready) begin
                    state_reg <= S_IDLE;
                    if (res_reg.last) begin
                        in_col_reg   <= '0;
                        in_row_reg   <= '0;
                        in_srow_reg  <= '0;
                        out_col_reg  <= '0;
                        out_row_reg  <= '0;
                        in_cnt_reg   <= '0;
                        out_cnt_reg  <= '0;
                        received_reg <= 1'b0;
                    end else if ({1'b0, out_col_reg} + 1'b1 >= (CB+1)'(w_eff)) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 1'b1;
                        out_cnt_reg <= out_cnt_reg + 1'b1;
                    end else begin
                        out_col_reg <= out_col_reg + 1'b1;
                        out_cnt_reg <= out_cnt_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== bench/local_mean_std_window_filter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// local_mean_std_window_filter_tb
// Self-checking bench for the local mean / std window filter. A behavioral
// model of the filter predicts every result from the accepted pixel and
// flush transactions. A monitor compares each result with the oldest
// prediction. Stimulus is a directed part (defaults, clamped registers,
// border and pixel extremes, ignored items), a clamped-width row, a partial
// tall frame, then random frames, first with random stalls on both streams, then at full rate.
// ----------------------------------------------------------------------------
module local_mean_std_window_filter_tb;

    // worst window read plus math, with margin
    localparam int SETTLE_CYCLES = 400;
    localparam int CB = lmsw_pkg::COL_BITS;
    localparam int RB = lmsw_pkg::ROW_BITS;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    local_mean_std_window_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Model state: raw register values, raster counters, row store
    // ------------------------------------------------------------------
    logic [10:0]  reg_w;
    logic [12:0]  reg_h;
    logic [2:0]   reg_r;
    int unsigned  in_col, in_row, out_col, out_row;
    bit           frame_in;
    logic [15:0]  row_store [0:lmsw_pkg::DEPTH-1];

    lmsw_pkg::result_t pending_results[$];

    bit           idle_en;
    int           errors;
    int           results_seen;
    int           frames_done;
    int           cfg_writes;
    int           items_sent;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("[local_mean_std_window_filter] ERROR");
        $display("timeout at %0t, %0d results still expected", $time,
                 pending_results.size());
        $finish;
    end

    function automatic int unsigned clamp(int unsigned v, int unsigned lo,
                                          int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // bitwise integer square root, floor
    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void restart_frame();
        in_col   = 0;
        in_row   = 0;
        out_col  = 0;
        out_row  = 0;
        frame_in = 1'b0;
    endfunction

    function automatic void model_config(logic [1:0] idx, logic [12:0] val);
        case (idx)
            lmsw_pkg::REG_WIDTH:  reg_w = val[10:0];
            lmsw_pkg::REG_HEIGHT: reg_h = val;
            lmsw_pkg::REG_RADIUS: reg_r = val[2:0];
            default:    return;   // unmapped index: no effect
        endcase
        restart_frame();
    endfunction

    // Updates the model for one accepted transaction, queues any result.
    function automatic void predict_filter(logic op, logic [15:0] pix);
        int unsigned     w, h, r, x0, x1, y0, y1, n, x, y;
        longint unsigned total, in_cnt, out_idx, lag, s, s2, v, vr;
        lmsw_pkg::result_t e;
        w = clamp(reg_w, 1, lmsw_pkg::MAX_WIDTH);
        h = clamp(reg_h, 1, lmsw_pkg::MAX_HEIGHT);
        r = clamp(reg_r, 0, lmsw_pkg::MAX_RADIUS);
        if (op == lmsw_pkg::OP_PIXEL) begin
            if (frame_in) return;     // pixel past frame end: dropped
            row_store[(in_row % lmsw_pkg::STORE_ROWS) * lmsw_pkg::MAX_WIDTH + in_col] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (in_row >= h) begin
                    in_row   = 0;
                    frame_in = 1'b1;
                end
            end
        end else if (!frame_in) begin
            return;                   // early flush: dropped
        end
        total   = longint'(w) * h;
        in_cnt  = frame_in ? total : longint'(in_row) * w + in_col;
        out_idx = longint'(out_row) * w + out_col;
        lag     = longint'(r) * w + r;
        if (out_idx >= total) return;
        if (!frame_in && in_cnt < out_idx + lag + 1) return;

        x0 = out_col >= r ? out_col - r : 0;
        x1 = out_col + r < w ? out_col + r : w - 1;
        y0 = out_row >= r ? out_row - r : 0;
        y1 = out_row + r < h ? out_row + r : h - 1;
        n  = (x1 - x0 + 1) * (y1 - y0 + 1);
        s  = 0;
        s2 = 0;
        for (y = y0; y <= y1; y++)
            for (x = x0; x <= x1; x++) begin
                v   = row_store[(y % lmsw_pkg::STORE_ROWS) * lmsw_pkg::MAX_WIDTH + x];
                s  += v;
                s2 += v * v;
            end
        vr     = longint'(n) * s2 - s * s;
        e.mean = 24'((s << 8) / n);
        e.sd   = 24'(root64(vr << 16) / n);
        e.col  = CB'(out_col);
        e.row  = RB'(out_row);
        e.last = (out_col == w - 1) && (out_row == h - 1);
        pending_results.push_back(e);
        if (e.last) begin
            restart_frame();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure and checking
    // ------------------------------------------------------------------
    initial begin : m_ready_gen
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (idle_en && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 17);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     exp_v, act_v);
        end
    endfunction

    always @(posedge aclk) begin : monitor
        lmsw_pkg::result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
            end else begin
                e = pending_results.pop_front();
                check_field("mean_value", e.mean, m_tdata[23:0]);
                check_field("std_value", e.sd, m_tdata[47:24]);
                check_field("out_column", e.col, m_tdata[57:48]);
                check_field("out_row", e.row, m_tdata[69:58]);
                check_field("frame_last", e.last, m_tlast);
                if (e.last) frames_done++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(logic op, logic [15:0] pix);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = pix;
        do @(posedge aclk); while (!s_tready);
        predict_filter(op, pix);
        items_sent++;
    endtask

    // let everything drain, then the block's own settle time
    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        model_config(idx, val);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_frame(logic [12:0] w, logic [12:0] h, logic [12:0] r);
        wait_quiet();
        write_reg(lmsw_pkg::REG_WIDTH, w);
        write_reg(lmsw_pkg::REG_HEIGHT, h);
        write_reg(lmsw_pkg::REG_RADIUS, r);
    endtask

    // flush until the model says the frame is drained
    task automatic drain_frame();
        while (frame_in) send_item(lmsw_pkg::OP_FLUSH, 16'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // reset geometry: lag is over a row, so nothing comes out yet
        send_item(lmsw_pkg::OP_FLUSH, 16'hFFFF);        // early flush, ignored
        send_item(lmsw_pkg::OP_PIXEL, 16'h0000);
        send_item(lmsw_pkg::OP_PIXEL, 16'hFFFF);
        send_item(lmsw_pkg::OP_PIXEL, 16'h5A5A);
        // 3x2 frame, radius 1: clipped window everywhere
        set_frame(13'd3, 13'd2, 13'd1);
        write_reg(2'd3, 13'h1FFF);                      // unmapped index
        send_item(lmsw_pkg::OP_PIXEL, 16'h0000);
        send_item(lmsw_pkg::OP_PIXEL, 16'hFFFF);
        send_item(lmsw_pkg::OP_PIXEL, 16'h0001);
        send_item(lmsw_pkg::OP_PIXEL, 16'hFFFF);
        send_item(lmsw_pkg::OP_PIXEL, 16'h0000);
        send_item(lmsw_pkg::OP_PIXEL, 16'h8000);
        send_item(lmsw_pkg::OP_PIXEL, 16'h1234);        // past frame end, ignored
        drain_frame();
        send_item(lmsw_pkg::OP_FLUSH, 16'h0000);        // nothing pending, ignored
        // zero width and height clamp to 1x1; largest radius
        set_frame(13'd0, 13'd0, 13'd7);
        send_item(lmsw_pkg::OP_PIXEL, 16'hFFFF);
        drain_frame();
        // flat max frame, radius 0: max mean, zero std
        set_frame(13'd4, 13'd2, 13'd0);
        repeat (8) send_item(lmsw_pkg::OP_PIXEL, 16'hFFFF);
        drain_frame();
    endtask

    task automatic test_full_row();
        set_frame(13'd2047, 13'd1, 13'd0);    // width clamps to 1024
        repeat (24) send_item(lmsw_pkg::OP_PIXEL, 16'($urandom));
    endtask

    task automatic test_tall_partial();
        set_frame(13'd1, 13'h1FFF, 13'd2);    // height clamps to 4096
        repeat (20) send_item(lmsw_pkg::OP_PIXEL, 16'($urandom));
        set_frame(13'd1024, 13'd4096, 13'd5); // abandon partial frame
        repeat (6) send_item(lmsw_pkg::OP_PIXEL, 16'($urandom));
    endtask

    task automatic test_random_frames(int target, bit hold_once);
        int  start, w, h, r, npix, i, cut, kind;
        bit  held;
        logic [15:0] pix;
        start = items_sent;
        held  = !hold_once;
        while (items_sent - start < target) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40)
                                            : $urandom_range(1, 10);
            h = $urandom_range(1, 8);
            r = $urandom_range(0, 7);
            if ($urandom_range(0, 15) == 0) w = 0;
            set_frame(13'(w), 13'(h), 13'(r));
            npix = clamp(w, 1, lmsw_pkg::MAX_WIDTH) * h;
            kind = $urandom_range(0, 3);      // 0: flat, else random content
            pix  = 16'($urandom);
            cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, npix - 1)
                                               : npix;
            if ($urandom_range(0, 9) == 0) send_item(lmsw_pkg::OP_FLUSH, 16'($urandom));
            for (i = 0; i < cut; i++) begin
                if (kind != 0) pix = 16'($urandom);
                send_item(lmsw_pkg::OP_PIXEL, pix);
                if (!held && i == npix / 2) begin
                    // sender holds until the block has caught up
                    @(negedge aclk);
                    s_tvalid = 1'b0;
                    while (pending_results.size() != 0) @(posedge aclk);
                    held = 1'b1;
                end
                if ($urandom_range(0, 29) == 0)
                    send_item(lmsw_pkg::OP_FLUSH, 16'($urandom));
            end
            if (cut == npix) begin
                if ($urandom_range(0, 4) == 0) send_item(lmsw_pkg::OP_PIXEL, 16'($urandom));
                drain_frame();
            end
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = lmsw_pkg::OP_PIXEL;
        cfg_valid    = 1'b0;
        cfg_index    = lmsw_pkg::REG_WIDTH;
        cfg_data     = '0;
        idle_en      = 1'b1;
        errors       = 0;
        results_seen = 0;
        frames_done  = 0;
        cfg_writes   = 0;
        items_sent   = 0;
        reg_w        = 11'd1024;
        reg_h        = 13'd1024;
        reg_r        = 3'd1;
        restart_frame();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_full_row();
        test_tall_partial();
        test_random_frames(480, 1'b1);
        idle_en = 1'b0;                       // closing stretch at full rate
        test_random_frames(80, 1'b0);
        wait_quiet();

        $display("covered %0d transactions, %0d register writes, %0d frames",
                 items_sent, cfg_writes, frames_done);
        $display("checked %0d results, %0d mismatches", results_seen, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("[local_mean_std_window_filter] OK");
        end else begin
            $display("[local_mean_std_window_filter] ERROR");
        end
        $finish;
    end

endmodule
